FILE: design/ipt_pkg.sv
// Shared types, codes and constants of the indexed pixel to RGB565 tint unit.
package ipt_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Command codes on the request port
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic REG_TINT_MODE = 1'b0;
  localparam logic REG_MACHINE_SELECT = 1'b1;

  // Tint modes; the unused code behaves as desaturate
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_COOL = 2'd1;
  localparam logic [1:0] MODE_DESAT = 2'd2;

  // Classified operations carried through the queue
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_BLANK = 2'd2;

  // Cool tint step and luminance weights
  localparam logic [7:0] COOL_STEP = 8'd20;
  localparam logic [7:0] COOL_BLUE_LIMIT = 8'd235;
  localparam logic [14:0] LUM_WEIGHT_R = 15'd30;
  localparam logic [14:0] LUM_WEIGHT_G = 15'd59;
  localparam logic [14:0] LUM_WEIGHT_B = 15'd11;
  // Divide by 100 as multiply by ceil(2^19 / 100), exact below 25600
  localparam logic [12:0] LUM_RECIP = 13'd5243;
  localparam int LUM_SHIFT = 19;

  typedef struct packed {
    logic [1:0] tint_mode;
    logic machine_select;
  } ipt_cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic table_choice;
    logic [PAL_AW-1:0] addr;
    logic [23:0] color;
  } ipt_item_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: design/ipt_front.sv
// Front end: classify incoming requests and hold them in a short queue.
module ipt_front import ipt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cmd,
  input  logic            table_choice,
  input  logic [7:0]      color_index,
  input  logic [23:0]     source_color,
  output logic            busy,
  output logic            item_valid,
  output ipt_item_t       item
);

  ipt_item_t             queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic [QUEUE_AW:0]     count_next;
  ipt_item_t             classified;
  logic                  in_range;
  logic                  push;
  logic                  pop;

  assign in_range = {1'b0, color_index} < 9'(PALETTE_ENTRIES);

  always_comb begin
    classified.table_choice = table_choice;
    classified.addr = color_index[PAL_AW-1:0];
    classified.color = source_color;
    if (cmd == CMD_LOAD) begin
      classified.op = OP_LOAD;
    end else if (in_range) begin
      classified.op = OP_PIXEL;
    end else begin
      classified.op = OP_BLANK;
    end
  end

  assign busy = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  // Drop loads outside the palette; they have no effect
  assign push = start && !busy && !(cmd == CMD_LOAD && !in_range);
  // The back end never stalls, so drain whenever something waits
  assign pop = (count != '0);
  assign item_valid = pop;
  assign item = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

endmodule

FILE: design/ipt_back.sv
// Back end: palette memories, tint pipeline and RGB565 result register.
module ipt_back import ipt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  ipt_cfg_t        cfg,
  input  logic            item_valid,
  input  ipt_item_t       item,
  output logic            result_valid,
  output logic [15:0]     rgb565
);

  logic [23:0] first_palette [PALETTE_ENTRIES];
  logic [23:0] second_palette [PALETTE_ENTRIES];

  // Stage A: memory read
  logic        valid_a;
  logic        blank_a;
  logic [23:0] first_rd;
  logic [23:0] second_rd;

  // Stage B: channel split, plain and cool paths, weighted sum
  logic [23:0] color_b_in;
  logic [7:0]  r_in, g_in, b_in;
  logic [1:0]  mode_in;
  logic [7:0]  r_cool, b_cool;
  logic [15:0] plain_in;
  logic [14:0] sum_in;
  logic        valid_b;
  logic        blank_b;
  logic        desat_b;
  logic [7:0]  r_b, g_b, b_b;
  logic [14:0] sum_b;
  logic [15:0] plain_b;

  // Stage C: luminance
  logic [27:0] lum_prod;
  logic        valid_c;
  logic        blank_c;
  logic        desat_c;
  logic [7:0]  r_c, g_c, b_c;
  logic [7:0]  lum_c;
  logic [15:0] plain_c;

  // Stage D: mix and pack
  logic [9:0]  r_mix, g_mix, b_mix;
  logic [15:0] final_color;

  logic is_load;
  logic is_read;

  assign is_load = item_valid && (item.op == OP_LOAD);
  assign is_read = item_valid && (item.op == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (is_load && !item.table_choice) begin
      first_palette[item.addr] <= item.color;
    end
    if (is_load && item.table_choice) begin
      second_palette[item.addr] <= item.color;
    end
    if (is_read) begin
      first_rd <= first_palette[item.addr];
      second_rd <= second_palette[item.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= item_valid && (item.op != OP_LOAD);
    end
    blank_a <= (item.op == OP_BLANK);
  end

  assign color_b_in = cfg.machine_select ? second_rd : first_rd;
  assign r_in = color_b_in[23:16];
  assign g_in = color_b_in[15:8];
  assign b_in = color_b_in[7:0];
  assign mode_in = cfg.machine_select ? cfg.tint_mode : MODE_PLAIN;
  assign r_cool = (r_in < COOL_STEP) ? 8'd0 : r_in - COOL_STEP;
  assign b_cool = (b_in > COOL_BLUE_LIMIT) ? 8'hFF : b_in + COOL_STEP;
  assign plain_in = (mode_in == MODE_COOL) ? pack565(r_cool, g_in, b_cool)
                                           : pack565(r_in, g_in, b_in);
  assign sum_in = {7'd0, r_in} * LUM_WEIGHT_R + {7'd0, g_in} * LUM_WEIGHT_G
                + {7'd0, b_in} * LUM_WEIGHT_B;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else begin
      valid_b <= valid_a;
    end
    blank_b <= blank_a;
    // Mode three behaves as desaturate
    desat_b <= mode_in[1];
    r_b <= r_in;
    g_b <= g_in;
    b_b <= b_in;
    sum_b <= sum_in;
    plain_b <= plain_in;
  end

  assign lum_prod = {13'd0, sum_b} * {15'd0, LUM_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else begin
      valid_c <= valid_b;
    end
    blank_c <= blank_b;
    desat_c <= desat_b;
    r_c <= r_b;
    g_c <= g_b;
    b_c <= b_b;
    lum_c <= lum_prod[LUM_SHIFT+7:LUM_SHIFT];
    plain_c <= plain_b;
  end

  // Three parts channel to one part luminance, truncated
  assign r_mix = {2'd0, r_c} + {1'b0, r_c, 1'b0} + {2'd0, lum_c};
  assign g_mix = {2'd0, g_c} + {1'b0, g_c, 1'b0} + {2'd0, lum_c};
  assign b_mix = {2'd0, b_c} + {1'b0, b_c, 1'b0} + {2'd0, lum_c};

  always_comb begin
    if (blank_c) begin
      final_color = 16'd0;
    end else if (desat_c) begin
      final_color = pack565(r_mix[9:2], g_mix[9:2], b_mix[9:2]);
    end else begin
      final_color = plain_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= valid_c;
    end
    rgb565 <= final_color;
  end

endmodule

FILE: design/indexed_pixel_to_rgb565_tint_unit.sv
// Top level of the indexed pixel to RGB565 tint unit.
//
// Use: a request is taken at a rising edge with start high and busy low.
// cmd selects a palette load (table_choice, color_index, source_color) or a
// pixel conversion (color_index). Loads give no result; each pixel request
// gives one rgb565 value, shown for exactly one cycle with result_valid high.
// The receiver cannot stall, so the back end drains the queue every cycle.
//
// Timing: one request per clock sustained. A pixel passes in order through the
// queue, palette read, channel split, luminance multiply, and mix and pack,
// each one register, before its result shows. Loads and pixels keep
// their order, so a pixel sees every load taken before it.
// busy rises only if the four-entry queue fills, which never happens while
// the back end drains one request per cycle.
//
// Configuration: cfg_valid/cfg_ready write tint_mode (index 0) or
// machine_select (index 1); cfg_ready is always high. Write only while idle.
// Reset clears the queue, the pipeline valids and both registers; palette
// contents stay undefined until loaded.
module indexed_pixel_to_rgb565_tint_unit import ipt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic        table_choice,
  input  logic [7:0]  color_index,
  input  logic [23:0] source_color,
  output logic        result_valid,
  output logic [15:0] rgb565,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  ipt_cfg_t  cfg;
  logic      item_valid;
  ipt_item_t item;

  // Accept configuration writes every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tint_mode <= MODE_PLAIN;
      cfg.machine_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TINT_MODE: begin
          cfg.tint_mode <= cfg_data;
        end
        REG_MACHINE_SELECT: begin
          cfg.machine_select <= cfg_data[0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Classify and queue requests
  ipt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .table_choice (table_choice),
    .color_index  (color_index),
    .source_color (source_color),
    .busy         (busy),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Load palettes, look up, tint and pack
  ipt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item         (item),
    .result_valid (result_valid),
    .rgb565       (rgb565)
  );

endmodule

FILE: tb/indexed_pixel_to_rgb565_tint_unit_test.sv
// Self-checking testbench for the indexed pixel to RGB565 tint unit.
`timescale 1ns / 1ps

module indexed_pixel_to_rgb565_tint_unit_test;
  import ipt_pkg::*;

  // Selector values and the spare tint code, which the block treats as desaturate
  localparam logic FIRST_TABLE = 1'b0;
  localparam logic SECOND_TABLE = 1'b1;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Tint arithmetic
  localparam int unsigned TINT_STEP = 20;
  localparam int unsigned CHANNEL_MAX = 255;
  localparam int unsigned WEIGHT_RED = 30;
  localparam int unsigned WEIGHT_GREEN = 59;
  localparam int unsigned WEIGHT_BLUE = 11;
  localparam int unsigned WEIGHT_SUM = 100;

  // Run control
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  // Holds a copy of both palettes and both registers; predicts each pixel
  // request and checks every result against the oldest prediction.
  class rgb565_scoreboard;
    logic [23:0] first_pal [256];
    logic [23:0] second_pal [256];
    logic [1:0] tint_mode = MODE_PLAIN;
    logic machine_select = 1'b0;
    logic [15:0] expected_rgb [$];
    int unsigned mismatches = 0;
    int unsigned loads = 0;
    int unsigned pixels = 0;
    int unsigned checked = 0;

    function void write_reg(logic idx, logic [1:0] data);
      if (idx == REG_TINT_MODE) tint_mode = data;
      else machine_select = data[0];
    endfunction

    function logic [15:0] shade(logic [23:0] color, bit tinted);
      int unsigned r, g, b, lum;
      logic [1:0] mode;
      logic [7:0] r8, g8, b8;
      r = color[23:16];
      g = color[15:8];
      b = color[7:0];
      mode = (tint_mode == MODE_SPARE) ? MODE_DESAT : tint_mode;
      if (tinted && mode == MODE_COOL) begin
        r = (r < TINT_STEP) ? 0 : r - TINT_STEP;
        b = (b + TINT_STEP > CHANNEL_MAX) ? CHANNEL_MAX : b + TINT_STEP;
      end else if (tinted && mode == MODE_DESAT) begin
        lum = (r * WEIGHT_RED + g * WEIGHT_GREEN + b * WEIGHT_BLUE) / WEIGHT_SUM;
        r = (r * 3 + lum) / 4;
        g = (g * 3 + lum) / 4;
        b = (b * 3 + lum) / 4;
      end
      r8 = r[7:0];
      g8 = g[7:0];
      b8 = b[7:0];
      return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    function void note_request(logic op, logic tc, logic [7:0] idx, logic [23:0] col);
      if (op == CMD_LOAD) begin
        loads++;
        if (tc == FIRST_TABLE) first_pal[idx] = col;
        else second_pal[idx] = col;
      end else begin
        pixels++;
        if (machine_select) expected_rgb.push_back(shade(second_pal[idx], 1'b1));
        else expected_rgb.push_back(shade(first_pal[idx], 1'b0));
      end
    endfunction

    function void check_pixel(logic [15:0] got);
      logic [15:0] want;
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: rgb565=%h with no pixel request pending", got);
        return;
      end
      want = expected_rgb.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("rgb565 mismatch: expected %h, got %h (result %0d)", want, got, checked);
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_LOAD;
  logic table_choice = FIRST_TABLE;
  logic [7:0] color_index = '0;
  logic [23:0] source_color = '0;
  logic result_valid;
  logic [15:0] rgb565;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_TINT_MODE;
  logic [1:0] cfg_data = MODE_PLAIN;

  rgb565_scoreboard pixel_book = new;

  // Entries that have been loaded; a pixel request only ever reads one of these
  bit first_loaded [256];
  bit second_loaded [256];
  logic [7:0] first_list [$];
  logic [7:0] second_list [$];

  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;

  indexed_pixel_to_rgb565_tint_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .table_choice(table_choice),
    .color_index(color_index),
    .source_color(source_color),
    .result_valid(result_valid),
    .rgb565(rgb565),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Results cannot be held off: check each one in the cycle it is shown
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) pixel_book.check_pixel(rgb565);
  end

  // Abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pixel_book.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void mark_loaded(logic tc, logic [7:0] idx);
    if (tc == FIRST_TABLE) begin
      if (!first_loaded[idx]) first_list.push_back(idx);
      first_loaded[idx] = 1'b1;
    end else begin
      if (!second_loaded[idx]) second_list.push_back(idx);
      second_loaded[idx] = 1'b1;
    end
  endfunction

  // Pick a random entry, falling back to a loaded one of the palette in use
  function automatic logic [7:0] pick_loaded_index(logic sel);
    logic [7:0] idx;
    idx = 8'($urandom_range(255));
    if (sel && !second_loaded[idx]) idx = second_list[$urandom_range(second_list.size() - 1)];
    if (!sel && !first_loaded[idx]) idx = first_list[$urandom_range(first_list.size() - 1)];
    return idx;
  endfunction

  // Present one request and hold it until the block takes it; leave start
  // high so that back-to-back requests need no gap.
  task automatic issue(input logic op, input logic tc, input logic [7:0] idx,
                       input logic [23:0] col);
    start <= 1'b1;
    cmd <= op;
    table_choice <= tc;
    color_index <= idx;
    source_color <= col;
    do @(posedge clk); while (busy !== 1'b0);
    pixel_book.note_request(op, tc, idx, col);
    if (op == CMD_LOAD) mark_loaded(tc, idx);
  endtask

  // Drop start for a burst of random length
  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  // Write one register, then drop valid before returning
  task automatic write_reg(input logic idx, input logic [1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pixel_book.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every pixel to come back, then let loads settle
  task automatic drain();
    start <= 1'b0;
    while (pixel_book.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random request: mostly pixels from loaded entries, with loads of
  // random entries mixed in; fields a request ignores carry noise.
  task automatic random_request();
    logic [23:0] col;
    col = 24'($urandom);
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(7))
        0: col = 24'h000000;
        1: col = 24'hFFFFFF;
        default: ;
      endcase
      issue(CMD_LOAD, 1'($urandom_range(1)), 8'($urandom_range(255)), col);
    end else begin
      issue(CMD_PIXEL, 1'($urandom_range(1)), pick_loaded_index(pixel_book.machine_select),
            col);
    end
  endtask

  initial begin
    logic [1:0] mode;
    logic sel;
    int idle_pct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes in both palettes; the second palette gets colours that sit on
    // and past the clamp points of the cool tint.
    issue(CMD_LOAD, FIRST_TABLE, 8'h00, 24'h000000);
    issue(CMD_LOAD, FIRST_TABLE, 8'hFF, 24'hFFFFFF);
    issue(CMD_LOAD, FIRST_TABLE, 8'h55, 24'hAA55AA);
    issue(CMD_LOAD, FIRST_TABLE, 8'hAA, 24'h55AA55);
    issue(CMD_LOAD, SECOND_TABLE, 8'h00, 24'h000000);
    issue(CMD_LOAD, SECOND_TABLE, 8'hFF, 24'hFFFFFF);
    issue(CMD_LOAD, SECOND_TABLE, 8'h55, 24'h1380EC);
    issue(CMD_LOAD, SECOND_TABLE, 8'hAA, 24'h1440EB);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Fixed settings first, covering every tint mode on the second palette
      // and a tint mode on the first, which that palette ignores, then random ones
      case (phase)
        0: begin mode = MODE_PLAIN; sel = 1'b0; end
        1: begin mode = MODE_PLAIN; sel = 1'b1; end
        2: begin mode = MODE_COOL; sel = 1'b1; end
        3: begin mode = MODE_DESAT; sel = 1'b1; end
        4: begin mode = MODE_SPARE; sel = 1'b1; end
        5: begin mode = MODE_COOL; sel = 1'b0; end
        default: begin mode = 2'($urandom_range(3)); sel = 1'($urandom_range(1)); end
      endcase
      drain();
      if ($urandom_range(1)) begin
        write_reg(REG_TINT_MODE, mode);
        write_reg(REG_MACHINE_SELECT, {1'b0, sel});
      end else begin
        write_reg(REG_MACHINE_SELECT, {1'b0, sel});
        write_reg(REG_TINT_MODE, mode);
      end
      settings_used++;

      // Read back the directed entries under this setting, noise on the rest
      issue(CMD_PIXEL, SECOND_TABLE, 8'h00, 24'hFFFFFF);
      issue(CMD_PIXEL, FIRST_TABLE, 8'hFF, 24'h000000);
      issue(CMD_PIXEL, SECOND_TABLE, 8'h55, 24'h5A5A5A);
      issue(CMD_PIXEL, FIRST_TABLE, 8'hAA, 24'hA5A5A5);

      // Vary the sender's idling per phase, none at all in the last one
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (phase == PHASES - 1) idle_pct = 0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_request();
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) pause_sender();
      end
    end

    drain();

    $display("ran %0d loads and %0d pixel requests over %0d register settings",
             pixel_book.loads, pixel_book.pixels, settings_used);
    $display("checked %0d results, %0d mismatches, %0d left outstanding", pixel_book.checked,
             pixel_book.mismatches, pixel_book.pending());
    if (pixel_book.mismatches == 0 && pixel_book.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
